FILE: src/ray_triangle_hit_test_unit_macros.svh
// Assertion helpers for the ray/triangle hit test unit.
`ifndef RAY_TRIANGLE_HIT_TEST_UNIT_MACROS_SVH
`define RAY_TRIANGLE_HIT_TEST_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RTHT_ASSERT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RTHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/rtht_pkg.sv
`default_nettype none

package rtht_pkg;

   localparam int CoordBits = 16;
   localparam int VtxW      = 3 * CoordBits;
   localparam int IdxW      = 8;
   localparam int EdgW      = CoordBits + 1;
   localparam int NpW       = 2 * EdgW;
   localparam int NW        = NpW + 1;
   localparam int MpW       = EdgW + NW;
   localparam int MW        = MpW + 1;
   localparam int PvW       = CoordBits + NW;
   localparam int VnW       = PvW + 2;
   localparam int PpW       = EdgW + NW;
   localparam int PW        = PpW + 2;
   localparam int DistW     = 32;
   localparam int FracBits  = 16;
   localparam int DivSteps  = DistW;
   localparam int RemW      = VnW;
   localparam int NumW      = PW;
   localparam int SatW      = RemW + FracBits;
   localparam int HpW       = DistW + 1 + CoordBits;
   localparam int HsW       = HpW + 1;
   localparam int HcW       = HsW - FracBits;
   localparam int EpW       = EdgW + MW;
   localparam int EsW       = EpW + 2;

   localparam int SIn    = 0;
   localparam int SOd    = 1;
   localparam int SMul   = 2;
   localparam int SSum   = 3;
   localparam int SAbs   = 4;
   localparam int SSat   = 5;
   localparam int SDiv0  = 6;
   localparam int ST     = SDiv0 + DivSteps;
   localparam int SHMul  = ST + 1;
   localparam int SH     = ST + 2;
   localparam int SA     = ST + 3;
   localparam int SEMul  = ST + 4;
   localparam int SESum  = ST + 5;
   localparam int SOut   = ST + 6;
   localparam int NS     = SOut + 1;

   typedef logic signed [CoordBits-1:0] coord_type;

   localparam coord_type CoordMax = {1'b0, {(CoordBits-1){1'b1}}};
   localparam coord_type CoordMin = {1'b1, {(CoordBits-1){1'b0}}};

   typedef enum logic [IdxW-1:0] {
      CSR_VERTEX_A     = 8'd0,
      CSR_VERTEX_B     = 8'd1,
      CSR_VERTEX_C     = 8'd2,
      CSR_DOUBLE_SIDED = 8'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] origin_x;
      logic signed [15:0] origin_y;
      logic signed [15:0] origin_z;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
   } req_type;

   typedef struct packed {
      logic               is_hit;
      logic [DistW-1:0]   hit_distance;
      logic signed [15:0] hit_x;
      logic signed [15:0] hit_y;
      logic signed [15:0] hit_z;
      logic               from_back;
   } rsp_type;

   function automatic int nxt3(input int i);
      return (i == 2) ? 0 : i + 1;
   endfunction

   function automatic int prv3(input int i);
      return (i == 0) ? 2 : i - 1;
   endfunction

   function automatic coord_type vcoord(input logic [VtxW-1:0] v, input int k);
      return v[k*CoordBits +: CoordBits];
   endfunction

   function automatic coord_type sat_coord(input logic signed [HcW-1:0] c);
      coord_type r;
      if (c > HcW'(CoordMax)) begin
         r = CoordMax;
      end else if (c < HcW'(CoordMin)) begin
         r = CoordMin;
      end else begin
         r = c[CoordBits-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: src/ray_triangle_hit_test_unit.sv
// Ray / triangle hit test unit.
// Program the triangle through the csr_ port: index 0..2 load vertices A, B, C
// (x, y, z as signed Q8.8 in bits 15:0, 31:16, 47:32), index 3 loads the
// double-sided flag. csr_ready is always high; other indexes are dropped.
// Write configuration only while no ray is in flight.
// Each ray enters on req_ (origin and direction, signed Q8.8) and yields exactly
// one response on rsp_: hit flag, Q16.16 distance, hit point and back-face flag.
// A miss returns all fields zero.
// One ray per cycle sustained while rsp_stall is low. The 32 radix-2 divider
// stages for the distance set the depth.
// The face normal is registered through np_ff and n_ff, and the edge normals
// through mp_ff and m_ff, after a vertex write, before any later ray reaches them.
// Reset empties the pipeline and clears the triangle to the origin, so every
// ray misses until vertices are written.
// When rsp_stall is high the response holds; earlier stages keep moving until
// bubbles are filled, and req_stall rises only when every stage is full.
`default_nettype none

module ray_triangle_hit_test_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  rtht_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output rtht_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rtht_pkg::IdxW-1:0]        csr_index,
   input  logic [rtht_pkg::VtxW-1:0]        csr_wdata
);
   import rtht_pkg::*;

`include "ray_triangle_hit_test_unit_macros.svh"

   logic [VtxW-1:0]         vtx_ff [3];
   logic                    dsided_ff;
   coord_type               vc [3][3];
   logic signed [EdgW-1:0]  e02 [3];
   logic signed [EdgW-1:0]  e01 [3];
   logic signed [EdgW-1:0]  edg [3][3];
   logic signed [NpW-1:0]   np_ff [3][2];
   logic signed [NW-1:0]    n_ff [3];
   logic signed [MpW-1:0]   mp_ff [3][3][2];
   logic signed [MW-1:0]    m_ff [3][3];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            vtx_ff[k] <= '0;
         end
         dsided_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_VERTEX_A: begin
               vtx_ff[0] <= csr_wdata;
            end
            CSR_VERTEX_B: begin
               vtx_ff[1] <= csr_wdata;
            end
            CSR_VERTEX_C: begin
               vtx_ff[2] <= csr_wdata;
            end
            CSR_DOUBLE_SIDED: begin
               dsided_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 3; i++) begin
            vc[k][i] = vcoord(vtx_ff[k], i);
         end
      end
      for (int i = 0; i < 3; i++) begin
         e02[i] = EdgW'(vc[2][i]) - EdgW'(vc[0][i]);
         e01[i] = EdgW'(vc[1][i]) - EdgW'(vc[0][i]);
      end
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 3; i++) begin
            edg[k][i] = EdgW'(vc[nxt3(k)][i]) - EdgW'(vc[k][i]);
         end
      end
   end

   // face normal n = (C - A) x (B - A), then per-edge normals m_k = e_k x n
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            np_ff[i][0] <= '0;
            np_ff[i][1] <= '0;
            n_ff[i]     <= '0;
            for (int k = 0; k < 3; k++) begin
               mp_ff[k][i][0] <= '0;
               mp_ff[k][i][1] <= '0;
               m_ff[k][i]     <= '0;
            end
         end
      end else begin
         for (int i = 0; i < 3; i++) begin
            np_ff[i][0] <= NpW'(e02[nxt3(i)]) * NpW'(e01[prv3(i)]);
            np_ff[i][1] <= NpW'(e02[prv3(i)]) * NpW'(e01[nxt3(i)]);
            n_ff[i]     <= NW'(np_ff[i][0]) - NW'(np_ff[i][1]);
            for (int k = 0; k < 3; k++) begin
               mp_ff[k][i][0] <= MpW'(edg[k][nxt3(i)]) * MpW'(n_ff[prv3(i)]);
               mp_ff[k][i][1] <= MpW'(edg[k][prv3(i)]) * MpW'(n_ff[nxt3(i)]);
               m_ff[k][i]     <= MW'(mp_ff[k][i][0]) - MW'(mp_ff[k][i][1]);
            end
         end
      end
   end

   // pipeline occupancy: a stage loads when rsp_stall is low or a bubble lies at or past it
   logic [NS-1:0] vld_ff;
   logic [NS-1:0] adv;

   for (genvar k = 0; k < NS; k++) begin : g_adv
      localparam logic [NS-1:0] LowMask = ~({NS{1'b1}} << k);
      assign adv[k] = !rsp_stall || !(&(vld_ff | LowMask));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[SIn]) begin
            vld_ff[SIn] <= req_valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   assign req_stall = !adv[SIn];

   // input stage
   req_type    in_ff;
   coord_type  in_o [3];
   coord_type  in_d [3];

   always_ff @(posedge clock) begin
      if (adv[SIn]) begin
         in_ff <= req_data;
      end
   end

   always_comb begin
      in_o[0] = in_ff.origin_x;
      in_o[1] = in_ff.origin_y;
      in_o[2] = in_ff.origin_z;
      in_d[0] = in_ff.dir_x;
      in_d[1] = in_ff.dir_y;
      in_d[2] = in_ff.dir_z;
   end

   // plane terms
   logic signed [EdgW-1:0] od_ff [3];
   coord_type              o1_ff [3];
   coord_type              d1_ff [3];
   logic signed [PvW-1:0]  pv_ff [3];
   logic signed [PpW-1:0]  pp_ff [3];
   coord_type              o2_ff [3];
   coord_type              d2_ff [3];
   logic signed [VnW-1:0]  vn_ff;
   logic signed [PW-1:0]   p_ff;
   coord_type              o3_ff [3];
   coord_type              d3_ff [3];

   always_ff @(posedge clock) begin
      if (adv[SOd]) begin
         for (int i = 0; i < 3; i++) begin
            od_ff[i] <= EdgW'(in_o[i]) - EdgW'(vc[0][i]);
            o1_ff[i] <= in_o[i];
            d1_ff[i] <= in_d[i];
         end
      end
      if (adv[SMul]) begin
         for (int i = 0; i < 3; i++) begin
            pv_ff[i] <= PvW'(d1_ff[i]) * PvW'(n_ff[i]);
            pp_ff[i] <= PpW'(od_ff[i]) * PpW'(n_ff[i]);
            o2_ff[i] <= o1_ff[i];
            d2_ff[i] <= d1_ff[i];
         end
      end
      if (adv[SSum]) begin
         vn_ff <= VnW'(pv_ff[0]) + VnW'(pv_ff[1]) + VnW'(pv_ff[2]);
         p_ff  <= PW'(pp_ff[0]) + PW'(pp_ff[1]) + PW'(pp_ff[2]);
         for (int i = 0; i < 3; i++) begin
            o3_ff[i] <= o2_ff[i];
            d3_ff[i] <= d2_ff[i];
         end
      end
   end

   // rejection tests and magnitudes
   logic                vn_zero;
   logic                vn_neg;
   logic                p_zero;
   logic                p_neg;
   logic                rej;
   logic [NumW-1:0]     num_ff;
   logic [RemW-1:0]     den_ff;
   logic                miss_ff [SAbs:ST-1];
   logic                back_ff [SAbs:ST-1];
   coord_type           so_ff [SAbs:ST-1][3];
   coord_type           sd_ff [SAbs:ST-1][3];

   always_comb begin
      vn_zero = (vn_ff == '0);
      vn_neg  = vn_ff[VnW-1];
      p_zero  = (p_ff == '0);
      p_neg   = p_ff[PW-1];
      rej     = vn_zero || (!vn_neg && !dsided_ff) || (!p_zero && (p_neg == vn_neg));
   end

   always_ff @(posedge clock) begin
      if (adv[SAbs]) begin
         num_ff        <= p_neg ? NumW'(-p_ff) : NumW'(p_ff);
         den_ff        <= vn_neg ? RemW'(-vn_ff) : RemW'(vn_ff);
         miss_ff[SAbs] <= rej;
         back_ff[SAbs] <= !vn_neg && !vn_zero;
         for (int i = 0; i < 3; i++) begin
            so_ff[SAbs][i] <= o3_ff[i];
            sd_ff[SAbs][i] <= d3_ff[i];
         end
      end
   end

   // divider: saturation check, then one quotient bit per stage
   logic [RemW-1:0]     rem_ff [DivSteps+1];
   logic [DistW-1:0]    q_ff   [DivSteps+1];
   logic [FracBits-1:0] lo_ff  [DivSteps+1];
   logic [RemW-1:0]     dd_ff  [DivSteps+1];
   logic                sat_ff [DivSteps+1];

   always_ff @(posedge clock) begin
      if (adv[SSat]) begin
         sat_ff[0]     <= SatW'(num_ff) >= {den_ff, FracBits'(0)};
         rem_ff[0]     <= RemW'(num_ff[NumW-1:FracBits]);
         lo_ff[0]      <= num_ff[FracBits-1:0];
         q_ff[0]       <= '0;
         dd_ff[0]      <= den_ff;
         miss_ff[SSat] <= miss_ff[SAbs];
         back_ff[SSat] <= back_ff[SAbs];
         for (int i = 0; i < 3; i++) begin
            so_ff[SSat][i] <= so_ff[SAbs][i];
            sd_ff[SSat][i] <= sd_ff[SAbs][i];
         end
      end
   end

   for (genvar s = 0; s < DivSteps; s++) begin : g_div
      logic [RemW:0] trial;
      logic [RemW:0] diff;
      logic          ge;

      always_comb begin
         trial = {rem_ff[s], lo_ff[s][FracBits-1]};
         diff  = trial - {1'b0, dd_ff[s]};
         ge    = trial >= {1'b0, dd_ff[s]};
      end

      always_ff @(posedge clock) begin
         if (adv[SDiv0+s]) begin
            rem_ff[s+1]        <= ge ? diff[RemW-1:0] : trial[RemW-1:0];
            q_ff[s+1]          <= {q_ff[s][DistW-2:0], ge};
            lo_ff[s+1]         <= {lo_ff[s][FracBits-2:0], 1'b0};
            dd_ff[s+1]         <= dd_ff[s];
            sat_ff[s+1]        <= sat_ff[s];
            miss_ff[SDiv0+s]   <= miss_ff[SDiv0+s-1];
            back_ff[SDiv0+s]   <= back_ff[SDiv0+s-1];
            for (int i = 0; i < 3; i++) begin
               so_ff[SDiv0+s][i] <= so_ff[SDiv0+s-1][i];
               sd_ff[SDiv0+s][i] <= sd_ff[SDiv0+s-1][i];
            end
         end
      end
   end

   // distance, hit point, edge tests
   logic [DistW-1:0]       t_ff;
   logic                   t_miss_ff;
   logic                   t_back_ff;
   coord_type              t_o_ff [3];
   coord_type              t_d_ff [3];
   logic signed [HpW-1:0]  ph_ff [3];
   coord_type              hm_o_ff [3];
   logic [DistW-1:0]       lt_t_ff [SHMul:SESum];
   logic                   lt_miss_ff [SHMul:SEMul];
   logic                   lt_back_ff [SHMul:SESum];
   coord_type              lt_h_ff [SH:SESum][3];
   logic signed [HsW-1:0]  hs [3];
   logic signed [EdgW-1:0] a_ff [3][3];
   logic signed [EpW-1:0]  ep_ff [3][3];
   logic signed [EsW-1:0]  es [3];
   logic                   ok_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         hs[i] = HsW'($signed({hm_o_ff[i], FracBits'(0)})) + HsW'(ph_ff[i]);
      end
      for (int k = 0; k < 3; k++) begin
         es[k] = EsW'(ep_ff[k][0]) + EsW'(ep_ff[k][1]) + EsW'(ep_ff[k][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST]) begin
         t_ff      <= sat_ff[DivSteps] ? '1 : q_ff[DivSteps];
         t_miss_ff <= miss_ff[ST-1];
         t_back_ff <= back_ff[ST-1];
         for (int i = 0; i < 3; i++) begin
            t_o_ff[i] <= so_ff[ST-1][i];
            t_d_ff[i] <= sd_ff[ST-1][i];
         end
      end
      if (adv[SHMul]) begin
         for (int i = 0; i < 3; i++) begin
            ph_ff[i]   <= HpW'($signed({1'b0, t_ff})) * HpW'(t_d_ff[i]);
            hm_o_ff[i] <= t_o_ff[i];
         end
         lt_t_ff[SHMul]    <= t_ff;
         lt_miss_ff[SHMul] <= t_miss_ff;
         lt_back_ff[SHMul] <= t_back_ff;
      end
      if (adv[SH]) begin
         for (int i = 0; i < 3; i++) begin
            lt_h_ff[SH][i] <= sat_coord($signed(hs[i][HsW-1:FracBits]));
         end
         lt_t_ff[SH]    <= lt_t_ff[SHMul];
         lt_miss_ff[SH] <= lt_miss_ff[SHMul];
         lt_back_ff[SH] <= lt_back_ff[SHMul];
      end
      if (adv[SA]) begin
         for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
               a_ff[k][i] <= EdgW'(lt_h_ff[SH][i]) - EdgW'(vc[k][i]);
            end
         end
         for (int i = 0; i < 3; i++) begin
            lt_h_ff[SA][i] <= lt_h_ff[SH][i];
         end
         lt_t_ff[SA]    <= lt_t_ff[SH];
         lt_miss_ff[SA] <= lt_miss_ff[SH];
         lt_back_ff[SA] <= lt_back_ff[SH];
      end
      if (adv[SEMul]) begin
         for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
               ep_ff[k][i] <= EpW'(a_ff[k][i]) * EpW'(m_ff[k][i]);
            end
         end
         for (int i = 0; i < 3; i++) begin
            lt_h_ff[SEMul][i] <= lt_h_ff[SA][i];
         end
         lt_t_ff[SEMul]    <= lt_t_ff[SA];
         lt_miss_ff[SEMul] <= lt_miss_ff[SA];
         lt_back_ff[SEMul] <= lt_back_ff[SA];
      end
      if (adv[SESum]) begin
         ok_ff <= !lt_miss_ff[SEMul] && !es[0][EsW-1] && !es[1][EsW-1] && !es[2][EsW-1];
         for (int i = 0; i < 3; i++) begin
            lt_h_ff[SESum][i] <= lt_h_ff[SEMul][i];
         end
         lt_t_ff[SESum]    <= lt_t_ff[SEMul];
         lt_back_ff[SESum] <= lt_back_ff[SEMul];
      end
   end

   // output register
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (adv[SOut]) begin
         rsp_ff.is_hit       <= ok_ff;
         rsp_ff.hit_distance <= ok_ff ? lt_t_ff[SESum] : '0;
         rsp_ff.hit_x        <= ok_ff ? lt_h_ff[SESum][0] : '0;
         rsp_ff.hit_y        <= ok_ff ? lt_h_ff[SESum][1] : '0;
         rsp_ff.hit_z        <= ok_ff ? lt_h_ff[SESum][2] : '0;
         rsp_ff.from_back    <= ok_ff && lt_back_ff[SESum];
      end
   end

   assign rsp_valid = vld_ff[SOut];
   assign rsp_data  = rsp_ff;

   `RTHT_ASSERT(a_miss_clean, clock, reset, rsp_valid && !rsp_data.is_hit, rsp_data[$bits(rsp_type)-2:0] == '0, "miss carries data")
   `RTHT_ASSERT(a_back_needs_ds, clock, reset, rsp_valid && rsp_data.from_back, rsp_data.is_hit && dsided_ff, "back hit not allowed")
   `RTHT_ASSERT(a_no_stall_empty, clock, reset, !rsp_valid, !req_stall, "input stalled while output empty")
   `RTHT_ASSERT_NEXT(a_drain, clock, reset, rsp_valid && !rsp_stall && !vld_ff[SESum], !rsp_valid, "output did not drain")

endmodule

`default_nettype wire

FILE: tb/sv/rtht_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rtht_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  rtht_pkg::req_type          req_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  rtht_pkg::rsp_type          rsp_data,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [rtht_pkg::IdxW-1:0]  csr_index,
   input  logic [rtht_pkg::VtxW-1:0]  csr_wdata,
   output int                         errors,
   output int                         pending
);
   import rtht_pkg::*;

   typedef logic signed [127:0] wint;
   typedef wint vec3[3];

   logic [VtxW-1:0] tri_vertex[3];
   logic            tri_double_sided;
   rsp_type         hit_queue[$];

   function automatic vec3 cross_vec(input vec3 a, input vec3 b);
      vec3 r;
      r[0] = a[1] * b[2] - a[2] * b[1];
      r[1] = a[2] * b[0] - a[0] * b[2];
      r[2] = a[0] * b[1] - a[1] * b[0];
      return r;
   endfunction

   function automatic wint dot_vec(input vec3 a, input vec3 b);
      return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
   endfunction

   function automatic rsp_type trace_ray(input req_type r);
      vec3             v[3];
      vec3             org, dir, e02, e01, nrm, rel, ed, cr;
      vec3             hp;
      wint             vn, p, num, den, tw, acc, cc;
      logic [31:0]     t;
      logic            back;
      rsp_type         res;
      res = '0;
      for (int k = 0; k < 3; k++)
         for (int i = 0; i < 3; i++)
            v[k][i] = $signed(tri_vertex[k][16*i +: 16]);
      org[0] = r.origin_x; org[1] = r.origin_y; org[2] = r.origin_z;
      dir[0] = r.dir_x;    dir[1] = r.dir_y;    dir[2] = r.dir_z;
      for (int i = 0; i < 3; i++) begin
         e02[i] = v[2][i] - v[0][i];
         e01[i] = v[1][i] - v[0][i];
         rel[i] = org[i] - v[0][i];
      end
      nrm = cross_vec(e02, e01);
      vn  = dot_vec(dir, nrm);
      p   = dot_vec(nrm, rel);
      if (vn == 0) return res;
      back = vn > 0;
      if (back && !tri_double_sided) return res;
      if (p != 0 && ((p > 0) == (vn > 0))) return res;
      num = (p < 0) ? -p : p;
      den = (vn < 0) ? -vn : vn;
      if (num / den >= 65536) t = 32'hFFFF_FFFF;
      else t = 32'((num <<< 16) / den);
      tw = {96'b0, t};
      for (int i = 0; i < 3; i++) begin
         acc = org[i] * 65536 + tw * dir[i];
         cc  = acc >>> 16;
         if (cc > 32767) hp[i] = 32767;
         else if (cc < -32768) hp[i] = -32768;
         else hp[i] = cc;
      end
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 3; i++) begin
            rel[i] = hp[i] - v[k][i];
            ed[i]  = v[(k + 1) % 3][i] - v[k][i];
         end
         cr = cross_vec(rel, ed);
         if (dot_vec(cr, nrm) < 0) return res;
      end
      res.is_hit       = 1'b1;
      res.hit_distance = t;
      res.hit_x        = hp[0][15:0];
      res.hit_y        = hp[1][15:0];
      res.hit_z        = hp[2][15:0];
      res.from_back    = back;
      return res;
   endfunction

   assign pending = hit_queue.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         tri_vertex[0] <= '0;
         tri_vertex[1] <= '0;
         tri_vertex[2] <= '0;
         tri_double_sided <= 1'b0;
         hit_queue.delete();
         errors <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_VERTEX_A:     tri_vertex[0] <= csr_wdata;
               CSR_VERTEX_B:     tri_vertex[1] <= csr_wdata;
               CSR_VERTEX_C:     tri_vertex[2] <= csr_wdata;
               CSR_DOUBLE_SIDED: tri_double_sided <= csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            hit_queue.push_back(trace_ray(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (hit_queue.size() == 0) begin
               $error("unexpected transaction on rsp");
               errors <= errors + 1;
            end else begin
               want = hit_queue.pop_front();
               if (want !== rsp_data) begin
                  if (want.is_hit !== rsp_data.is_hit)
                     $error("is_hit exp %0d got %0d", want.is_hit, rsp_data.is_hit);
                  if (want.hit_distance !== rsp_data.hit_distance)
                     $error("hit_distance exp %h got %h", want.hit_distance,
                            rsp_data.hit_distance);
                  if (want.hit_x !== rsp_data.hit_x)
                     $error("hit_x exp %0d got %0d", want.hit_x, rsp_data.hit_x);
                  if (want.hit_y !== rsp_data.hit_y)
                     $error("hit_y exp %0d got %0d", want.hit_y, rsp_data.hit_y);
                  if (want.hit_z !== rsp_data.hit_z)
                     $error("hit_z exp %0d got %0d", want.hit_z, rsp_data.hit_z);
                  if (want.from_back !== rsp_data.from_back)
                     $error("from_back exp %0d got %0d", want.from_back,
                            rsp_data.from_back);
                  errors <= errors + 1;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
   import rtht_pkg::*;

   localparam logic [IdxW-1:0] CsrUnused = 8'hFF;
   localparam int CycleLimit = 2_000_000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [IdxW-1:0]     csr_index = '0;
   logic [VtxW-1:0]     csr_wdata = '0;
   int                  errors, pending;
   int                  send_idle_pct = 0, recv_stall_pct = 0;
   int                  cycles = 0;
   logic                req_fire = 1'b0, csr_fire = 1'b0;
   logic signed [15:0]  tri_pt[3][3];

   always #1 clock = ~clock;

   ray_triangle_hit_test_unit DUT (.*);

   rtht_checker u_checker (.*);

   always @(posedge clock) begin
      req_fire <= req_valid && !req_stall;
      csr_fire <= csr_valid && csr_ready;
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_stall <= !reset && ($urandom_range(99) < recv_stall_pct);

   task automatic write_reg(input logic [IdxW-1:0] idx, input logic [VtxW-1:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      do @(negedge clock); while (!csr_fire);
      csr_valid = 1'b0;
   endtask

   task automatic load_triangle(input logic double_sided);
      write_reg(CSR_VERTEX_A, {tri_pt[0][2], tri_pt[0][1], tri_pt[0][0]});
      write_reg(CSR_VERTEX_B, {tri_pt[1][2], tri_pt[1][1], tri_pt[1][0]});
      write_reg(CSR_VERTEX_C, {tri_pt[2][2], tri_pt[2][1], tri_pt[2][0]});
      write_reg(CSR_DOUBLE_SIDED, {47'($urandom), double_sided});
   endtask

   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic send_ray(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = r;
      do @(negedge clock); while (!req_fire);
   endtask

   function automatic logic signed [15:0] clamp16(input int x);
      if (x > 32767) return 16'sh7FFF;
      if (x < -32768) return 16'sh8000;
      return 16'(x);
   endfunction

   function automatic req_type mk_ray(input int ox, oy, oz, dx, dy, dz);
      req_type r;
      r.origin_x = clamp16(ox); r.origin_y = clamp16(oy); r.origin_z = clamp16(oz);
      r.dir_x = clamp16(dx); r.dir_y = clamp16(dy); r.dir_z = clamp16(dz);
      return r;
   endfunction

   function automatic req_type aimed_ray(input int span);
      int w0, w1, w2, tgt[3], org[3], k;
      req_type r;
      w0 = $urandom_range(256);
      w1 = $urandom_range(256 - w0);
      w2 = 256 - w0 - w1;
      k  = 1 << $urandom_range(4);
      for (int i = 0; i < 3; i++) begin
         tgt[i] = (w0 * tri_pt[0][i] + w1 * tri_pt[1][i] + w2 * tri_pt[2][i]) / 256;
         org[i] = tgt[i] + $signed($urandom_range(2 * span)) - span;
      end
      r = mk_ray(org[0], org[1], org[2], (tgt[0] - org[0]) / k,
                 (tgt[1] - org[1]) / k, (tgt[2] - org[2]) / k);
      return r;
   endfunction

   initial begin
      int span, nrays;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      send_ray(mk_ray(0, 0, -256, 0, 0, 256));
      req_valid = 1'b0;
      drain();

      tri_pt[0] = '{16'sd0, 16'sd0, 16'sd0};
      tri_pt[1] = '{16'sd256, 16'sd0, 16'sd0};
      tri_pt[2] = '{16'sd0, 16'sd256, 16'sd0};
      load_triangle(1'b0);
      write_reg(CsrUnused, '1);
      write_reg(8'(CSR_DOUBLE_SIDED) + 8'd1, '1);
      send_ray(mk_ray(64, 64, -256, 0, 0, 256));
      send_ray(mk_ray(64, 64, 256, 0, 0, -256));
      send_ray(mk_ray(64, 64, -256, 256, 0, 0));
      send_ray(mk_ray(64, 64, -256, 0, 0, 0));
      send_ray(mk_ray(64, 64, 0, 0, 0, 256));
      send_ray(mk_ray(64, 64, 256, 0, 0, 256));
      send_ray(mk_ray(0, 0, -256, 0, 0, 256));
      send_ray(mk_ray(256, 0, -1, 0, 0, 1));
      send_ray(mk_ray(400, 400, -256, 0, 0, 256));
      send_ray(mk_ray(64, 64, -32768, 0, 0, 1));
      send_ray(mk_ray(32767, 32767, -32768, -32768, -32768, 32767));
      send_ray(mk_ray(-32768, -32768, -32768, 32767, 32767, 32767));
      send_ray(mk_ray(-1, -1, -1, 32767, -32768, 32767));
      req_valid = 1'b0;
      drain();
      write_reg(CSR_DOUBLE_SIDED, 48'd1);
      send_ray(mk_ray(64, 64, 256, 0, 0, -256));
      send_ray(mk_ray(64, 64, 256, 0, 0, 256));
      send_ray(mk_ray(0, 0, 32767, 0, 0, -32768));
      req_valid = 1'b0;
      drain();

      tri_pt[0] = '{16'sh7FFF, 16'sh8000, 16'sh7FFF};
      tri_pt[1] = '{16'sh8000, 16'sh7FFF, 16'sh8000};
      tri_pt[2] = '{16'sh8000, 16'sh8000, 16'sh7FFF};
      load_triangle(1'b1);
      send_ray(mk_ray(0, 0, 0, 256, 0, 0));
      send_ray(mk_ray(0, 0, 0, 0, 0, -256));
      send_ray(mk_ray(-32768, -32768, -32768, 1, 1, 1));
      send_ray(aimed_ray(2000));

      for (int ph = 0; ph < 8; ph++) begin
         req_valid = 1'b0;
         drain();
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
         endcase
         span = (ph == 3) ? 32767 : (128 << (ph % 6));
         for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++)
               tri_pt[k][i] = (ph >= 6) ? 16'($urandom)
                                        : clamp16($signed($urandom_range(2 * span)) - span);
         load_triangle(1'(ph % 2));
         nrays = 230;
         for (int n = 0; n < nrays; n++) begin
            if ($urandom_range(99) < 75) send_ray(aimed_ray(span));
            else send_ray(req_type'({$urandom, $urandom, $urandom}));
         end
      end
      req_valid = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain();
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: ray_triangle_hit_test_unit.f
+incdir+src
src/rtht_pkg.sv
src/ray_triangle_hit_test_unit.sv
tb/sv/rtht_checker.sv
tb/sv/tb_top.sv
